FILE: sv/gea_pkg.sv
// ----------------------------------------------------------------------------
// gea_pkg
// Operation and status codes shared by the generational entity allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gea_pkg;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_DEAD   = 2'd2,
        STATUS_BEYOND = 2'd3
    } t_status;

endpackage

`default_nettype wire

FILE: sv/generational_entity_allocator.sv
// ----------------------------------------------------------------------------
// generational_entity_allocator
// Hands out slot/generation handles, with a free list threaded through the
// slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Present an operation with start high; it is taken at a clock edge where
//   busy is low. busy is then high for one cycle while the slot entry read in
//   the accept cycle is checked, modified and written back.
//   The result appears on the o_result_* ports with o_done high for exactly
//   one cycle, the cycle after busy. The receiver cannot stall the block.
//   The entry read at accept is checked and written back while busy, then the
//   result is shown with o_done; no new item is taken while busy, and
//   the next item may be accepted in the cycle that o_done is shown.
//   Each slot entry holds generation, next-free link and alive bit. Entries
//   below the used-slot count have always been written, so the table needs
//   no clearing pass: after a synchronous reset the block takes an item in
//   the very next cycle, with an empty free list and no used slots.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_entity_allocator
    import gea_pkg::*;
#(
    parameter int SLOT_COUNT      = 1024,
    parameter int GENERATION_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_entity_index,
    input  wire logic [GENERATION_BITS-1:0]   i_entity_generation,
    output logic                              o_done,
    output logic [$clog2(SLOT_COUNT)-1:0]     o_result_index,
    output logic [GENERATION_BITS-1:0]        o_result_generation,
    output logic                              o_alive,
    output logic [1:0]                        o_status
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int GEN_W = GENERATION_BITS;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    // entry: {alive, link_empty, link, generation}
    localparam int ENT_W = GEN_W + IDX_W + 2;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOT_COUNT);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;

    logic             r_free_empty, n_free_empty;
    logic [IDX_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0] r_used, n_used;

    // captured item
    t_op              r_op;
    logic [IDX_W-1:0] r_idx;
    logic [GEN_W-1:0] r_gen;
    logic [IDX_W-1:0] r_addr;
    logic             r_in_range;
    logic             r_use_free;
    logic             r_has_fresh;

    logic [IDX_W-1:0] n_result_index;
    logic [GEN_W-1:0] n_result_generation;
    logic             n_alive;
    t_status          n_status;

    logic             w_accept;
    t_op              w_op;
    logic [IDX_W-1:0] w_rd_addr;
    logic [ENT_W-1:0] w_rd_data;
    logic             w_wr_en;
    logic [ENT_W-1:0] w_wr_data;

    logic [GEN_W-1:0] w_ent_gen;
    logic [IDX_W-1:0] w_ent_link;
    logic             w_ent_link_empty;
    logic             w_ent_alive;

    assign busy     = (r_state == ST_EXEC);
    assign w_accept = start && !busy;
    assign w_op     = t_op'(i_operation);

    always_comb begin
        if (w_op == OP_CREATE) begin
            w_rd_addr = r_free_empty ? r_used[IDX_W-1:0] : r_free_head;
        end else begin
            w_rd_addr = i_entity_index;
        end
    end

    // write back only in the execute cycle; while idle the captured item is stale
    gea_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W),
        .DW    (ENT_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en && busy),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data)
    );

    assign w_ent_gen        = w_rd_data[GEN_W-1:0];
    assign w_ent_link       = w_rd_data[GEN_W+IDX_W-1:GEN_W];
    assign w_ent_link_empty = w_rd_data[GEN_W+IDX_W];
    assign w_ent_alive      = w_rd_data[ENT_W-1];

    // check, modify and write back the entry read in the accept cycle
    always_comb begin
        w_wr_en             = 1'b0;
        w_wr_data           = w_rd_data;
        n_free_empty        = r_free_empty;
        n_free_head         = r_free_head;
        n_used              = r_used;
        n_result_index      = r_idx;
        n_result_generation = r_gen;
        n_alive             = 1'b0;
        n_status            = STATUS_OK;
        case (r_op)
            OP_CREATE: begin
                if (r_use_free) begin
                    w_wr_en             = 1'b1;
                    w_wr_data           = {1'b1, w_ent_link_empty, w_ent_link,
                                           w_ent_gen + GEN_W'(1)};
                    n_free_empty        = w_ent_link_empty;
                    n_free_head         = w_ent_link;
                    n_result_index      = r_addr;
                    n_result_generation = w_ent_gen + GEN_W'(1);
                    n_alive             = 1'b1;
                end else if (r_has_fresh) begin
                    w_wr_en             = 1'b1;
                    w_wr_data           = {1'b1, 1'b1, {IDX_W{1'b0}}, {GEN_W{1'b0}}};
                    n_used              = r_used + CNT_W'(1);
                    n_result_index      = r_addr;
                    n_result_generation = '0;
                    n_alive             = 1'b1;
                end else begin
                    n_result_index      = '0;
                    n_result_generation = '0;
                    n_status            = STATUS_FULL;
                end
            end
            OP_REMOVE, OP_QUERY: begin
                if (!r_in_range) begin
                    n_status = STATUS_BEYOND;
                end else if (!w_ent_alive || w_ent_gen != r_gen) begin
                    n_status = STATUS_DEAD;
                end else if (r_op == OP_REMOVE) begin
                    // push slot on the free list head, generation kept
                    w_wr_en      = 1'b1;
                    w_wr_data    = {1'b0, r_free_empty, r_free_head, w_ent_gen};
                    n_free_empty = 1'b0;
                    n_free_head  = r_idx;
                end else begin
                    n_alive = 1'b1;
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_empty <= 1'b1;
            r_free_head  <= '0;
            r_used       <= '0;
            o_done       <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_free_empty        <= n_free_empty;
                    r_free_head         <= n_free_head;
                    r_used              <= n_used;
                    o_done              <= 1'b1;
                    o_result_index      <= n_result_index;
                    o_result_generation <= n_result_generation;
                    o_alive             <= n_alive;
                    o_status            <= n_status;
                    r_state             <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= w_op;
            r_idx       <= i_entity_index;
            r_gen       <= i_entity_generation;
            r_addr      <= w_rd_addr;
            r_in_range  <= CNT_W'(i_entity_index) < r_used;
            r_use_free  <= !r_free_empty;
            r_has_fresh <= (r_used != FULL_COUNT);
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute phase longer than one cycle");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_COUNT)
        else $error("used slot count beyond table size");

    a_head_in_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_free_empty |-> (CNT_W'(r_free_head) < r_used))
        else $error("free list head outside used slots");

    a_fail_not_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != STATUS_OK) |-> !o_alive)
        else $error("failed item reports a live handle");

endmodule

`default_nettype wire

FILE: sv/gea_slot_ram.sv
// ----------------------------------------------------------------------------
// gea_slot_ram
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gea_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
